// ===== rtl/qpr_pkg.sv =====
// Shared types and constants for the quasi proportional-resonant controller.
// Used by qpr_step, quasi_pr_controller and qpr_checker; depends on nothing.
`default_nettype none

package qpr_pkg;

	localparam int COEF_W             = 32;
	localparam int LIMIT_W            = 31;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 32;
	localparam int DEF_DATA_WIDTH     = 32;
	localparam int DEF_COEF_FRAC_BITS = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN = 3'd0,
		REG_RES_B0    = 3'd1,
		REG_FB_A1     = 3'd2,
		REG_FB_A2     = 3'd3,
		REG_OUT_LIMIT = 3'd4
	} reg_idx_t;

	// Coefficient set, all signed with COEF_FRAC_BITS fraction bits.
	typedef struct packed {
		logic signed [COEF_W-1:0] prop;
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

endpackage

`default_nettype wire

// ===== rtl/quasi_pr_controller.sv =====
// Quasi proportional-resonant controller: input register, combinational update
// in qpr_step, history registers and output register. Uses qpr_pkg, qpr_step.
//
// Usage:
//   The s_axis channel takes one error sample word per control tick; the
//   m_axis channel returns one word per sample: the limited output in tdata
//   and the saturation flag in tuser. The cfg channel writes coefficient
//   registers by index (0 kp, 1 b0, 2 a1, 3 a2, 4 limit); cfg_ready is always
//   high. A write to a valid index clears the four history samples, while an
//   index beyond the list is ignored. Write registers only while no sample
//   is in flight.
//   Path: a sample accepted into the input register passes through qpr_step
//   and is loaded into the output register once m_axis can advance. Throughput:
//   one sample per cycle while m_axis is not stalled; the resonant history feeds
//   back within that cycle, through four parallel multipliers, an adder and the clamp logic.
//   Reset clears all coefficients, the limit (so the output is zero until a
//   limit is written), the history and both valid flags.
//   When m_axis_tready is low, the result word holds, one further sample is
//   taken into the input register, and s_axis_tready then drops.
`default_nettype none

module quasi_pr_controller #(
	parameter int DATA_WIDTH     = qpr_pkg::DEF_DATA_WIDTH,
	parameter int COEF_FRAC_BITS = qpr_pkg::DEF_COEF_FRAC_BITS,
	localparam int TDATA_W       = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [TDATA_W-1:0]                s_axis_tdata,  // error_sample
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [TDATA_W-1:0]                     m_axis_tdata,  // control_out
	output logic [0:0]                             m_axis_tuser,  // saturated
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [qpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DW = DATA_WIDTH;

	logic                            v_s1;
	logic signed [DW-1:0]            err_s1;
	qpr_pkg::coef_t                  coef_q;
	qpr_pkg::coef_t                  coef_d;
	logic [qpr_pkg::LIMIT_W-1:0]     limit_q;
	logic [qpr_pkg::LIMIT_W-1:0]     limit_d;
	logic                            cfg_hit;
	logic signed [DW-1:0]            err_h1_q;
	logic signed [DW-1:0]            err_h2_q;
	logic signed [DW-1:0]            res_h1_q;
	logic signed [DW-1:0]            res_h2_q;
	logic                            out_valid_q;
	logic [DW-1:0]                   out_data_q;
	logic                            out_sat_q;
	logic                            adv;
	logic                            fire;
	logic signed [DW-1:0]            ctl_out;
	logic                            sat;
	logic signed [DW-1:0]            res_next;

	assign adv           = !out_valid_q || m_axis_tready;
	assign fire          = v_s1 && adv;
	assign s_axis_tready = !v_s1 || adv;
	assign cfg_ready     = 1'b1;

	always_comb begin
		coef_d  = coef_q;
		limit_d = limit_q;
		cfg_hit = 1'b0;
		if (cfg_valid && cfg_ready) begin
			cfg_hit = 1'b1;
			unique case (qpr_pkg::reg_idx_t'(cfg_index))
				qpr_pkg::REG_PROP_GAIN: coef_d.prop = signed'(cfg_data);
				qpr_pkg::REG_RES_B0:    coef_d.b0   = signed'(cfg_data);
				qpr_pkg::REG_FB_A1:     coef_d.a1   = signed'(cfg_data);
				qpr_pkg::REG_FB_A2:     coef_d.a2   = signed'(cfg_data);
				qpr_pkg::REG_OUT_LIMIT: limit_d     = cfg_data[qpr_pkg::LIMIT_W-1:0];
				default:                cfg_hit     = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			limit_q <= '0;
		end else begin
			coef_q  <= coef_d;
			limit_q <= limit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			err_s1 <= signed'(s_axis_tdata[DW-1:0]);
		end
	end

	qpr_step #(
		.DATA_WIDTH     (DATA_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_step (
		.coef     (coef_q),
		.limit    (limit_q),
		.err      (err_s1),
		.err_h2   (err_h2_q),
		.res_h1   (res_h1_q),
		.res_h2   (res_h2_q),
		.ctl_out  (ctl_out),
		.sat      (sat),
		.res_next (res_next)
	);

	// A register write restarts the filter from rest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_h1_q <= '0;
			err_h2_q <= '0;
			res_h1_q <= '0;
			res_h2_q <= '0;
		end else if (cfg_hit) begin
			err_h1_q <= '0;
			err_h2_q <= '0;
			res_h1_q <= '0;
			res_h2_q <= '0;
		end else if (fire) begin
			err_h1_q <= err_s1;
			err_h2_q <= err_h1_q;
			res_h1_q <= res_next;
			res_h2_q <= res_h1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= ctl_out;
			out_sat_q  <= sat;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = TDATA_W'(out_data_q);
	assign m_axis_tuser[0] = out_sat_q;

endmodule

`default_nettype wire

// ===== rtl/qpr_step.sv =====
// Combinational update of the controller for one error sample: resonant sum,
// proportional term, symmetric clamp and back-calculation. Uses qpr_pkg.
`default_nettype none

module qpr_step #(
	parameter int DATA_WIDTH     = qpr_pkg::DEF_DATA_WIDTH,
	parameter int COEF_FRAC_BITS = qpr_pkg::DEF_COEF_FRAC_BITS
) (
	input  var qpr_pkg::coef_t                 coef,
	input  wire logic [qpr_pkg::LIMIT_W-1:0]   limit,
	input  wire logic signed [DATA_WIDTH-1:0]  err,
	input  wire logic signed [DATA_WIDTH-1:0]  err_h2,
	input  wire logic signed [DATA_WIDTH-1:0]  res_h1,
	input  wire logic signed [DATA_WIDTH-1:0]  res_h2,
	output logic signed [DATA_WIDTH-1:0]       ctl_out,
	output logic                               sat,
	output logic signed [DATA_WIDTH-1:0]       res_next
);

	localparam int DW  = DATA_WIDTH;
	localparam int CF  = COEF_FRAC_BITS;
	localparam int PW  = qpr_pkg::COEF_W + DW;
	localparam int AW  = PW + 3;
	localparam int RW  = AW - CF;
	localparam int PSW = PW - CF;
	localparam int LW  = ((DW > qpr_pkg::LIMIT_W + 1) ? DW : qpr_pkg::LIMIT_W + 1) + 1;

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	logic signed [DW:0]     e_diff;
	logic signed [PW:0]     prod_b;
	logic signed [PW-1:0]   prod_a1;
	logic signed [PW-1:0]   prod_a2;
	logic signed [PW-1:0]   prod_p;
	logic signed [AW-1:0]   acc;
	logic signed [RW-1:0]   acc_sh;
	logic signed [PSW-1:0]  prop_sh;
	logic signed [DW-1:0]   res_sat;
	logic signed [DW-1:0]   prop_sat;
	logic [LW-1:0]          lim_ext;
	logic signed [DW-1:0]   lim;
	logic signed [DW:0]     lim1;
	logic signed [DW:0]     total;
	logic signed [DW:0]     limited;
	logic signed [DW+1:0]   lim2;
	logic signed [DW+1:0]   back;
	logic signed [DW+1:0]   back_cl;

	// b0*e + b2*e2 with b2 = -b0 folds into one product of the difference.
	assign e_diff  = (DW+1)'(err) - (DW+1)'(err_h2);
	assign prod_b  = coef.b0 * e_diff;
	assign prod_a1 = coef.a1 * res_h1;
	assign prod_a2 = coef.a2 * res_h2;
	assign prod_p  = coef.prop * err;

	assign acc = AW'(prod_b) - AW'(prod_a1) - AW'(prod_a2);

	// Dropping the fraction bits of a two's complement value rounds toward minus infinity.
	assign acc_sh  = acc[AW-1:CF];
	assign prop_sh = prod_p[PW-1:CF];

	always_comb begin
		logic [RW-DW:0]  res_hi;
		logic [PSW-DW:0] prop_hi;
		res_hi  = acc_sh[RW-1:DW-1];
		prop_hi = prop_sh[PSW-1:DW-1];
		if ((&res_hi) || !(|res_hi)) begin
			res_sat = acc_sh[DW-1:0];
		end else begin
			res_sat = acc_sh[RW-1] ? DMIN : DMAX;
		end
		if ((&prop_hi) || !(|prop_hi)) begin
			prop_sat = prop_sh[DW-1:0];
		end else begin
			prop_sat = prop_sh[PSW-1] ? DMIN : DMAX;
		end
	end

	// The clamp magnitude never exceeds the largest positive sample.
	assign lim_ext = LW'(limit);
	assign lim     = (lim_ext > LW'(DMAX)) ? DMAX : signed'(lim_ext[DW-1:0]);
	assign lim1    = (DW+1)'(lim);
	assign lim2    = (DW+2)'(lim);

	assign total = (DW+1)'(prop_sat) + (DW+1)'(res_sat);

	always_comb begin
		sat = 1'b1;
		if (total > lim1) begin
			limited = lim1;
		end else if (total < -lim1) begin
			limited = -lim1;
		end else begin
			limited = total;
			sat     = 1'b0;
		end
	end

	assign back = (DW+2)'(limited) - (DW+2)'(prop_sat);

	always_comb begin
		if (back > lim2) begin
			back_cl = lim2;
		end else if (back < -lim2) begin
			back_cl = -lim2;
		end else begin
			back_cl = back;
		end
	end

	assign ctl_out  = limited[DW-1:0];
	assign res_next = sat ? back_cl[DW-1:0] : res_sat;

endmodule

`default_nettype wire

// ===== rtl/qpr_checker.sv =====
// Port-level checks for quasi_pr_controller, attached by the bind below.
// Uses qpr_pkg for the configuration port widths and the default data width.
`default_nettype none

module qpr_port_checker #(
	parameter int DATA_WIDTH     = qpr_pkg::DEF_DATA_WIDTH,
	localparam int TDATA_W       = ((DATA_WIDTH + 7) / 8) * 8
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [TDATA_W-1:0]               m_axis_tdata,
	input wire logic [0:0]                       m_axis_tuser,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [qpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input wire logic [qpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [1:0] inflight_q;
	logic       in_acc;
	logic       out_acc;
	logic       cfg_seen;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_acc  = m_axis_tvalid && m_axis_tready;
	assign cfg_seen = cfg_valid && (|cfg_index || |cfg_data);

	// Words accepted but not yet delivered; the block holds at most two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready && (cfg_ready || !cfg_seen))
		else $error("input not ready while the output side is empty");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 2'd0)
		else $error("result word without an accepted input word");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two words held inside the block");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[DATA_WIDTH-1:0] != MOST_NEG)
		else $error("saturated output beyond the symmetric limit");

endmodule

bind quasi_pr_controller qpr_port_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qpr_checker (.*);

`default_nettype wire
